// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the line stepper RTL.
// Expects a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define ASSERT_CHK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== hw/rtl/lps_pkg.sv =====
// Shared types and constants for the line pixel stepper.
// No dependencies.
`default_nettype none

package lps_pkg;

  localparam int unsigned DIM_BITS = 15;
  localparam int unsigned CFG_IDX_BITS = 1;

  localparam logic [DIM_BITS-1:0] DIM_RESET = 15'd1024;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'd1;

  // Item function codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  typedef struct packed {
    logic has_pixel;
    logic visible;
    logic last;
  } pix_flags_t;

endpackage

`default_nettype wire

// ===== hw/rtl/line_pixel_stepper_core.sv =====
// Top level of the line pixel stepper: input register, tracer, result register.
// Depends on lps_pkg, lps_tracer and assert_macros.svh.
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_ready    func, start_x, start_y, end_x, end_y, color
//   out       output     out_valid / out_ready  pixel_x, pixel_y, pixel_color, visible, last
//   cfg       input      cfg_we                 cfg_index, cfg_data
//
// One item per cycle sustained while the result register is not stalled; each
// transaction is captured in the input register, and its pixel is then loaded
// into the result register. The rate is set by the error update in the tracer.
// Reset (synchronous) empties both registers, clears the line and sets the
// image size to 1024 x 1024. A stalled result blocks only items that make a pixel.
`default_nettype none
`include "assert_macros.svh"

module line_pixel_stepper_core #(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 func,
  input  wire logic [COORD_BITS-1:0]                start_x,
  input  wire logic [COORD_BITS-1:0]                start_y,
  input  wire logic [COORD_BITS-1:0]                end_x,
  input  wire logic [COORD_BITS-1:0]                end_y,
  input  wire logic [31:0]                          color,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic      [COORD_BITS-1:0]                pixel_x,
  output logic      [COORD_BITS-1:0]                pixel_y,
  output logic      [31:0]                          pixel_color,
  output logic                                      visible,
  output logic                                      last,
  input  wire logic                                 cfg_we,
  input  wire logic [lps_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [lps_pkg::DIM_BITS-1:0]         cfg_data
);

  // configuration
  logic [lps_pkg::DIM_BITS-1:0] image_width;
  logic [lps_pkg::DIM_BITS-1:0] image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= lps_pkg::DIM_RESET;
      image_height <= lps_pkg::DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lps_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        lps_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic                  s1_valid, s1_valid_next;
  logic                  s1_func;
  logic [COORD_BITS-1:0] s1_ax, s1_ay, s1_bx, s1_by;
  logic [31:0]           s1_color;
  logic                  fire;
  logic                  out_load;
  logic                  out_valid_next;

  lps_pkg::pix_flags_t   flags;
  logic [COORD_BITS-1:0] px, py;
  logic [31:0]           pcolor;

  // an item that makes no pixel never waits on the result register
  assign fire     = s1_valid && (!flags.has_pixel || !out_valid || out_ready);
  assign out_load = fire && flags.has_pixel;
  assign in_ready = !s1_valid || fire;

  always_comb begin
    s1_valid_next = s1_valid;
    if (in_valid && in_ready) begin
      s1_valid_next = 1'b1;
    end else if (fire) begin
      s1_valid_next = 1'b0;
    end
    out_valid_next = out_valid;
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= s1_valid_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_func  <= func;
      s1_ax    <= start_x;
      s1_ay    <= start_y;
      s1_bx    <= end_x;
      s1_by    <= end_y;
      s1_color <= color;
    end
  end

  lps_tracer #(
    .COORD_BITS(COORD_BITS)
  ) u_tracer (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .func        (s1_func),
    .ax          (s1_ax),
    .ay          (s1_ay),
    .bx          (s1_bx),
    .by          (s1_by),
    .color       (s1_color),
    .image_width (image_width),
    .image_height(image_height),
    .flags       (flags),
    .px          (px),
    .py          (py),
    .pcolor      (pcolor)
  );

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      pixel_x     <= px;
      pixel_y     <= py;
      pixel_color <= pcolor;
      visible     <= flags.visible;
      last        <= flags.last;
    end
  end

  `ASSERT_ALWAYS(a_stall_needs_item, !in_ready |-> s1_valid,
                 "input stalled with an empty input register")
  `ASSERT_CHK(a_pixel_lands, out_load |=> out_valid,
              "pixel transaction lost on its way to the result register")
  `ASSERT_CHK(a_no_overwrite, (out_valid && !out_ready) |-> !out_load,
              "waiting result overwritten")

endmodule

`default_nettype wire

// ===== hw/rtl/lps_tracer.sv =====
// Line state and Bresenham step/setup datapath of the line pixel stepper.
// Depends on lps_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lps_tracer #(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               fire,
  input  wire logic                               func,
  input  wire logic [COORD_BITS-1:0]              ax,
  input  wire logic [COORD_BITS-1:0]              ay,
  input  wire logic [COORD_BITS-1:0]              bx,
  input  wire logic [COORD_BITS-1:0]              by,
  input  wire logic [31:0]                        color,
  input  wire logic [lps_pkg::DIM_BITS-1:0]       image_width,
  input  wire logic [lps_pkg::DIM_BITS-1:0]       image_height,
  output lps_pkg::pix_flags_t                     flags,
  output logic      [COORD_BITS-1:0]              px,
  output logic      [COORD_BITS-1:0]              py,
  output logic      [31:0]                        pcolor
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned CMP_W = (CW > lps_pkg::DIM_BITS) ? CW : lps_pkg::DIM_BITS;

  // line state
  logic                 busy;
  logic                 steep;
  logic signed [CW-1:0] major_pos;
  logic signed [CW-1:0] major_end;
  logic signed [CW-1:0] minor_pos;
  logic                 minor_step_neg;
  logic [CW:0]          major_delta;
  logic [CW:0]          minor_delta;
  logic signed [CW+1:0] error_term;
  logic [31:0]          line_color;

  // setup path
  logic signed [CW:0]   dx, dy, dmin;
  logic [CW:0]          adx, ady;
  logic                 setup_steep, setup_swap;
  logic signed [CW-1:0] a_maj, a_min, b_maj, b_min;
  logic signed [CW-1:0] lo_maj, lo_min, hi_maj, hi_min;
  logic [CW:0]          setup_major_delta;

  always_comb begin
    dx = {bx[CW-1], bx} - {ax[CW-1], ax};
    dy = {by[CW-1], by} - {ay[CW-1], ay};
    adx = dx[CW] ? (CW+1)'(-dx) : dx;
    ady = dy[CW] ? (CW+1)'(-dy) : dy;
    setup_steep = ady > adx;
    a_maj = setup_steep ? $signed(ay) : $signed(ax);
    a_min = setup_steep ? $signed(ax) : $signed(ay);
    b_maj = setup_steep ? $signed(by) : $signed(bx);
    b_min = setup_steep ? $signed(bx) : $signed(by);
    setup_swap = a_maj > b_maj;
    lo_maj = setup_swap ? b_maj : a_maj;
    lo_min = setup_swap ? b_min : a_min;
    hi_maj = setup_swap ? a_maj : b_maj;
    hi_min = setup_swap ? a_min : b_min;
    setup_major_delta = {hi_maj[CW-1], hi_maj} - {lo_maj[CW-1], lo_maj};
    dmin = {hi_min[CW-1], hi_min} - {lo_min[CW-1], lo_min};
  end

  // step path
  logic                 fin;
  logic signed [CW+1:0] err_sub, err_fix;
  logic                 vis_x, vis_y;

  always_comb begin
    px = steep ? minor_pos : major_pos;
    py = steep ? major_pos : minor_pos;
    fin = major_pos >= major_end;
    vis_x = !px[CW-1] && (CMP_W'(px) < CMP_W'(image_width));
    vis_y = !py[CW-1] && (CMP_W'(py) < CMP_W'(image_height));
    err_sub = error_term - $signed({1'b0, minor_delta});
    err_fix = err_sub + $signed({1'b0, major_delta});
    flags.has_pixel = (func == lps_pkg::FUNC_STEP) && busy;
    flags.visible = vis_x && vis_y;
    flags.last = fin;
    pcolor = line_color;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (fire) begin
      if (func == lps_pkg::FUNC_START) begin
        busy <= 1'b1;
      end else if (busy && fin) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (func == lps_pkg::FUNC_START) begin
        steep          <= setup_steep;
        major_pos      <= lo_maj;
        major_end      <= hi_maj;
        minor_pos      <= lo_min;
        minor_step_neg <= !(lo_min < hi_min);
        major_delta    <= setup_major_delta;
        minor_delta    <= dmin[CW] ? (CW+1)'(-dmin) : dmin;
        error_term     <= $signed({2'b00, setup_major_delta[CW:1]});
        line_color     <= color;
      end else if (busy && !fin) begin
        major_pos <= major_pos + 1'b1;
        // take a minor step when the error goes negative
        if (err_sub[CW+1]) begin
          error_term <= err_fix;
          minor_pos  <= minor_step_neg ? minor_pos - 1'b1 : minor_pos + 1'b1;
        end else begin
          error_term <= err_sub;
        end
      end
    end
  end

  `ASSERT_CHK(a_pos_in_range, busy |-> (major_pos <= major_end),
              "major position passed the line end")
  `ASSERT_CHK(a_error_nonneg, busy |-> !error_term[CW+1],
              "error term left negative after a step")
  `ASSERT_CHK(a_last_ends_line, (fire && flags.has_pixel && flags.last) |=> !busy,
              "line still busy after its last pixel")
  `ASSERT_CHK(a_idle_holds_pos, (busy && !fire) |=> $stable(major_pos),
              "major position moved without a transaction")

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for line_pixel_stepper_core: line starts, pixel steps, image size.
// Depends on lps_pkg and the line_pixel_stepper_core RTL; nothing else.
`timescale 1ns / 100ps

module tb_top;

  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE = 6;
  localparam int HOLD_CYCLES = 60;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] rgba;
    logic        vis;
    logic        fin;
  } pixel_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic                             func = lps_pkg::FUNC_STEP;
  logic [15:0]                      start_x = '0;
  logic [15:0]                      start_y = '0;
  logic [15:0]                      end_x = '0;
  logic [15:0]                      end_y = '0;
  logic [31:0]                      color = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [15:0]                      pixel_x;
  logic [15:0]                      pixel_y;
  logic [31:0]                      pixel_color;
  logic                             visible;
  logic                             last;
  logic                             cfg_we = 1'b0;
  logic [lps_pkg::CFG_IDX_BITS-1:0] cfg_index = lps_pkg::REG_IMAGE_WIDTH;
  logic [lps_pkg::DIM_BITS-1:0]     cfg_data = '0;

  line_pixel_stepper_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .start_x(start_x), .start_y(start_y),
    .end_x(end_x), .end_y(end_y), .color(color),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .pixel_color(pixel_color),
    .visible(visible), .last(last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Line tracer state, kept in step with the block
  int          img_w = 1024;
  int          img_h = 1024;
  bit          tracing = 0;
  bit          line_steep = 0;
  bit          minor_down = 0;
  int          major_at = 0;
  int          major_stop = 0;
  int          minor_at = 0;
  int          major_span = 0;
  int          minor_span = 0;
  int          err_acc = 0;
  logic [31:0] line_rgba = '0;

  pixel_t pixel_q[$];
  pixel_t want;
  int     errors = 0;
  int     item_count = 0;
  int     src_idle = 0;
  int     dst_idle = 0;
  int     hold_len = 0;
  int     hold_reqs = 0;
  int     hold_seen = 0;
  int     quiet = 0;

  function automatic int mag(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int clamp16(int v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  // Advance the tracer by one transaction; returns 1 when a pixel is due.
  function automatic bit trace_item(logic f, logic signed [15:0] sx, logic signed [15:0] sy,
                                    logic signed [15:0] ex, logic signed [15:0] ey,
                                    logic [31:0] col);
    int     ax, ay, bx, by, t, px, py;
    pixel_t p;
    if (f == lps_pkg::FUNC_START) begin
      ax = int'(sx);
      ay = int'(sy);
      bx = int'(ex);
      by = int'(ey);
      line_steep = mag(by - ay) > mag(bx - ax);
      if (line_steep) begin
        t = ax; ax = ay; ay = t;
        t = bx; bx = by; by = t;
      end
      if (ax > bx) begin
        t = ax; ax = bx; bx = t;
        t = ay; ay = by; by = t;
      end
      major_at = ax;
      major_stop = bx;
      minor_at = ay;
      major_span = bx - ax;
      minor_span = mag(by - ay);
      minor_down = !(ay < by);
      err_acc = major_span / 2;
      line_rgba = col;
      tracing = 1'b1;
      return 1'b0;
    end
    if (!tracing) return 1'b0;
    px = line_steep ? minor_at : major_at;
    py = line_steep ? major_at : minor_at;
    p.x = px[15:0];
    p.y = py[15:0];
    p.rgba = line_rgba;
    p.vis = px >= 0 && py >= 0 && px < img_w && py < img_h;
    p.fin = major_at >= major_stop;
    pixel_q.push_back(p);
    if (p.fin) begin
      tracing = 1'b0;
    end else begin
      err_acc -= minor_span;
      if (err_acc < 0) begin
        err_acc += major_span;
        minor_at += minor_down ? -1 : 1;
      end
      major_at++;
    end
    return 1'b1;
  endfunction

  task automatic compare_field(string what, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pixel_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel, expected none, actual x=%h y=%h",
                 $time, pixel_x, pixel_y);
      end else begin
        want = pixel_q.pop_front();
        compare_field("pixel_x", 32'(want.x), 32'(pixel_x));
        compare_field("pixel_y", 32'(want.y), 32'(pixel_y));
        compare_field("pixel_color", want.rgba, pixel_color);
        compare_field("visible", 32'(want.vis), 32'(visible));
        compare_field("last", 32'(want.fin), 32'(last));
      end
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_len <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_len > 0) begin
      out_ready <= 1'b0;
      hold_len <= hold_len - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= dst_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("line_pixel_stepper_core verification failed");
        $finish;
      end
    end
  end

  task automatic send_item(input logic f, input logic [15:0] sx, input logic [15:0] sy,
                           input logic [15:0] ex, input logic [15:0] ey,
                           input logic [31:0] col);
    bit produced;
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    start_x <= sx;
    start_y <= sy;
    end_x <= ex;
    end_y <= ey;
    color <= col;
    do @(posedge clk); while (!in_ready);
    produced = trace_item(f, sx, sy, ex, ey, col);
    if (produced || f == lps_pkg::FUNC_START) item_count++;
  endtask

  task automatic send_step();
    send_item(lps_pkg::FUNC_STEP, 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), $urandom);
  endtask

  task automatic send_line(int x0, int y0, int x1, int y1);
    send_item(lps_pkg::FUNC_START, x0[15:0], y0[15:0], x1[15:0], y1[15:0], $urandom);
  endtask

  // Hold the input until every pixel is out, then let the pipeline settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_image(int w, int h);
    cfg_we <= 1'b1;
    cfg_index <= lps_pkg::REG_IMAGE_WIDTH;
    cfg_data <= w[lps_pkg::DIM_BITS-1:0];
    @(posedge clk);
    img_w = w;
    cfg_index <= lps_pkg::REG_IMAGE_HEIGHT;
    cfg_data <= h[lps_pkg::DIM_BITS-1:0];
    @(posedge clk);
    img_h = h;
    cfg_we <= 1'b0;
  endtask

  function automatic int rand_dim();
    if ($urandom_range(4) == 0) return $urandom_range(32767, 1);
    return $urandom_range(48, 2);
  endfunction

  // Mostly inside the image or just past its edges, some at the coordinate extremes, some anywhere
  function automatic int pick_coord(int cat, int size);
    if (cat < 6) return clamp16(int'($urandom_range(size + 12)) - 6);
    if (cat < 8) begin
      if ($urandom_range(1)) return -32768 + int'($urandom_range(20));
      return 32767 - int'($urandom_range(20));
    end
    return int'($urandom_range(65535)) - 32768;
  endfunction

  task automatic random_lines(int goal);
    int stop, r, cat, span, x0, y0, x1, y1, n;
    stop = item_count + goal;
    while (item_count < stop) begin
      r = $urandom_range(99);
      if (r < 2) begin
        drain_results();
      end else if (r < 8) begin
        send_step();
      end else begin
        cat = $urandom_range(9);
        x0 = pick_coord(cat, img_w);
        y0 = pick_coord(cat, img_h);
        if (r < 16) begin
          // long line, cut short by the next start
          x1 = int'($urandom_range(65535)) - 32768;
          y1 = int'($urandom_range(65535)) - 32768;
          send_line(x0, y0, x1, y1);
          repeat ($urandom_range(6, 1)) send_step();
        end else begin
          span = ($urandom_range(9) == 0) ? 64 : 10;
          x1 = clamp16(x0 + int'($urandom_range(2 * span)) - span);
          y1 = clamp16(y0 + int'($urandom_range(2 * span)) - span);
          n = ((mag(x1 - x0) > mag(y1 - y0)) ? mag(x1 - x0) : mag(y1 - y0)) + 1;
          if (r < 26) n = $urandom_range(n);
          else if ($urandom_range(6) == 0) n++;
          send_line(x0, y0, x1, y1);
          repeat (n) send_step();
        end
      end
    end
  endtask

  task automatic test_idle_and_single_point();
    send_step();
    send_line(5, 7, 5, 7);
    send_step();
    send_step();
  endtask

  task automatic test_extreme_lines();
    send_line(-32768, 32767, 32767, -32768);
    repeat (2) send_step();
    // restart while the previous line is still open
    send_line(32767, -32768, 32765, -32765);
    repeat (4) send_step();
  endtask

  task automatic test_clip_edges();
    send_line(1024, 1021, 1022, 1026);
    repeat (6) send_step();
    send_line(1, 0, -1, 1);
    repeat (3) send_step();
    drain_results();
    set_image(0, 1024);
    send_line(0, 0, 0, 0);
    send_step();
  endtask

  task automatic test_image_sizes();
    drain_results();
    set_image(1, 1);
    random_lines(50);
    drain_results();
    set_image(32767, 32767);
    random_lines(50);
    drain_results();
    set_image(32767, 1);
    random_lines(50);
  endtask

  task automatic test_random_traffic(int sidle, int didle, int goal);
    drain_results();
    src_idle = sidle;
    dst_idle = didle;
    repeat (2) begin
      drain_results();
      set_image(rand_dim(), rand_dim());
      random_lines(goal / 2);
    end
  endtask

  task automatic test_output_stall();
    drain_results();
    set_image(160, 120);
    src_idle = 0;
    dst_idle = 0;
    hold_reqs++;
    send_line(100, 100, 180, 130);
    repeat (81) send_step();
    drain_results();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    src_idle = 31;
    dst_idle = 54;
    test_idle_and_single_point();
    test_extreme_lines();
    test_clip_edges();
    test_image_sizes();
    test_random_traffic(31, 54, 480);
    test_random_traffic(54, 31, 480);
    test_random_traffic(0, 0, 480);
    test_output_stall();
    drain_results();
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("line_pixel_stepper_core verification clean");
    end else begin
      $display("line_pixel_stepper_core verification failed");
    end
    $finish;
  end

endmodule
